// ----- rtl/core/wkt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkt_pkg: shared types and constants for the key table byte cipher
// Word widths, table geometry, mixing constants, unit op codes and the
// status bundle between the setup sequencer and the top level.
// ----------------------------------------------------------------------------
package wkt_pkg;

    localparam int WORD_W      = 32;
    localparam int TABLE_DEPTH = 256;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int KEY_WORDS   = 4;
    localparam int CFG_IDX_W   = 3;

    // add pass: entries ADD_START.. are added into 0..ADD_LAST
    localparam int ADD_START = 89;
    localparam int ADD_LAST  = 22;
    // entries that seed the whitening pass
    localparam int IDX_X_SEED = 33;
    localparam int IDX_Z_SEED = 59;

    localparam logic [WORD_W-1:0] WHITEN_MASK = 32'hFF7F_FFFF;
    localparam logic [WORD_W-1:0] LOW24_MASK  = 32'h00FF_FFFF;
    localparam logic [WORD_W-1:0] Z_SET_BITS  = 32'h0100_0001;

    localparam logic [1:0] BYTE_POS_MSB = 2'd3;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_key_words [KEY_WORDS];

    typedef enum logic {
        ALU_ADD,
        ALU_MASK_ADD
    } t_alu_op;

    typedef struct packed {
        t_word sum;
        t_word mix;
    } t_alu_res;

    typedef struct packed {
        logic  busy;
        t_word autokey;
    } t_seq_stat;

    function automatic t_word mix_const(input logic [2:0] sel);
        t_word c;
        case (sel)
            3'd0:    c = 32'h726a_8f3b;
            3'd1:    c = 32'he69a_3b5c;
            3'd2:    c = 32'hd3c7_1fe5;
            3'd3:    c = 32'hab3c_73d2;
            3'd4:    c = 32'h4d3a_8eb3;
            3'd5:    c = 32'h0396_d6e8;
            3'd6:    c = 32'h3d4c_2f7a;
            default: c = 32'h9ee2_7cf3;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/wkt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkt_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/wkt_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkt_alu: shared 32-bit adder of the setup sequencer
// Adds two words, optionally masking the first, and forms the fill mix.
// ----------------------------------------------------------------------------
module wkt_alu
    import wkt_pkg::*;
(
    input  t_alu_op  i_op,
    input  t_word    i_a,
    input  t_word    i_b,
    output t_alu_res o_res
);

    t_word w_a;
    t_word w_sum;

    always_comb begin
        case (i_op)
            ALU_MASK_ADD: w_a = i_a & WHITEN_MASK;
            default:      w_a = i_a;
        endcase
    end

    assign w_sum     = w_a + i_b;
    assign o_res.sum = w_sum;
    assign o_res.mix = (w_sum >> 3) ^ mix_const(w_sum[2:0]);

endmodule

// ----- rtl/core/wkt_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkt_seq: setup sequencer
// Builds the key table in RAM over the shared adder and derives the autokey.
// ----------------------------------------------------------------------------
module wkt_seq
    import wkt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_key_words i_key,
    output t_seq_stat  o_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_ADD_RA,
        S_ADD_RB,
        S_ADD_WR,
        S_WHT_INIT,
        S_WHT_RD,
        S_WHT_WR,
        S_PRM_RD1,
        S_PRM_RD2,
        S_PRM_RD3,
        S_PRM_WR1,
        S_PRM_WR2,
        S_AK_RD,
        S_AK_WR
    } t_state;

    localparam logic [TAB_AW-1:0] IDX_LAST = TAB_AW'(TABLE_DEPTH - 1);

    t_state            r_state, n_state;
    logic [TAB_AW-1:0] r_idx, n_idx;
    logic [1:0]        r_step, n_step;
    t_word             r_win [KEY_WORDS];
    t_word             n_win [KEY_WORDS];
    t_word             r_x, n_x;
    t_word             r_z, n_z;
    t_word             r_xseed, n_xseed;
    t_word             r_tail, n_tail;
    t_word             r_a, n_a;
    t_word             r_b, n_b;
    t_word             r_chain, n_chain;
    t_word             r_akey, n_akey;
    logic [WORD_W-9:0] r_hi, n_hi;

    t_alu_op           w_op;
    t_word             w_opa, w_opb;
    t_alu_res          w_res;
    logic              w_we;
    logic [TAB_AW-1:0] w_waddr, w_raddr;
    t_word             w_wdata;
    t_word             w_rdata;
    t_word             w_fill;
    t_word             w_ak;
    logic [7:0]        w_px;

    wkt_alu u_alu (
        .i_op  (w_op),
        .i_a   (w_opa),
        .i_b   (w_opb),
        .o_res (w_res)
    );

    wkt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_fill = (r_idx < TAB_AW'(KEY_WORDS)) ? i_key[r_idx[1:0]] : w_res.mix;
    assign w_ak   = {8'd0, r_hi} ^ w_rdata;
    assign w_px   = w_rdata[7:0] ^ r_x[7:0];

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_step  = r_step;
        n_win   = r_win;
        n_x     = r_x;
        n_z     = r_z;
        n_xseed = r_xseed;
        n_tail  = r_tail;
        n_a     = r_a;
        n_b     = r_b;
        n_chain = r_chain;
        n_akey  = r_akey;
        n_hi    = r_hi;
        w_op    = ALU_ADD;
        w_opa   = r_win[KEY_WORDS-1];
        w_opb   = r_win[0];
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_fill;
        w_raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_FILL;
                    n_idx   = '0;
                end
            end
            S_FILL: begin
                // sliding window holds the last four entries written
                w_we = 1'b1;
                for (int k = 0; k < KEY_WORDS - 1; k++) begin
                    n_win[k] = r_win[k+1];
                end
                n_win[KEY_WORDS-1] = w_fill;
                if (r_idx == TAB_AW'(IDX_X_SEED)) n_xseed = w_fill;
                if (r_idx == TAB_AW'(IDX_Z_SEED)) n_z = (w_fill | Z_SET_BITS) & WHITEN_MASK;
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_state = S_ADD_RA;
                end
            end
            S_ADD_RA: begin
                w_raddr = r_idx + TAB_AW'(ADD_START);
                n_state = S_ADD_RB;
            end
            S_ADD_RB: begin
                n_a     = w_rdata;
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                w_opa   = w_rdata;
                w_opb   = r_a;
                w_we    = 1'b1;
                w_wdata = w_res.sum;
                if (r_idx == TAB_AW'(ADD_LAST)) begin
                    n_idx   = '0;
                    n_state = S_WHT_INIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ADD_RA;
                end
            end
            S_WHT_INIT: begin
                w_op    = ALU_MASK_ADD;
                w_opa   = r_xseed;
                w_opb   = r_z;
                n_x     = w_res.sum;
                n_state = S_WHT_RD;
            end
            S_WHT_RD: begin
                n_state = S_WHT_WR;
            end
            S_WHT_WR: begin
                w_op    = ALU_MASK_ADD;
                w_opa   = r_x;
                w_opb   = r_z;
                w_we    = 1'b1;
                w_wdata = (w_rdata & LOW24_MASK) ^ w_res.sum;
                n_x     = w_res.sum;
                if (r_idx == '0) n_tail = w_wdata;
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_x     = {24'd0, w_res.sum[7:0]};
                    n_state = S_PRM_RD1;
                end else begin
                    n_state = S_WHT_RD;
                end
            end
            S_PRM_RD1: begin
                w_raddr = r_idx ^ r_x[7:0];
                n_state = S_PRM_RD2;
            end
            S_PRM_RD2: begin
                w_raddr = w_px;
                n_x     = {24'd0, w_px};
                n_state = S_PRM_RD3;
            end
            S_PRM_RD3: begin
                n_a     = w_rdata;
                w_raddr = r_idx + 1'b1;
                n_state = S_PRM_WR1;
            end
            S_PRM_WR1: begin
                w_we    = 1'b1;
                w_wdata = r_a;
                n_b     = (r_idx == IDX_LAST) ? r_tail : w_rdata;
                n_state = S_PRM_WR2;
            end
            S_PRM_WR2: begin
                w_we    = 1'b1;
                w_waddr = r_x[7:0];
                w_wdata = r_b;
                n_idx   = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_step  = '0;
                    n_state = S_AK_RD;
                end else begin
                    n_state = S_PRM_RD1;
                end
            end
            S_AK_RD: begin
                // M step: sum the pair, look up the low byte
                w_opa   = i_key[r_step];
                w_opb   = (r_step == '0) ? i_key[KEY_WORDS-1] : r_chain;
                w_raddr = w_res.sum[TAB_AW-1:0];
                n_hi    = w_res.sum[WORD_W-1:8];
                n_state = S_AK_WR;
            end
            S_AK_WR: begin
                n_step = r_step + 1'b1;
                if (r_step == 2'(KEY_WORDS - 1)) begin
                    n_akey  = w_ak;
                    n_state = S_IDLE;
                end else begin
                    n_chain = w_ak;
                    n_state = S_AK_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_akey  <= '0;
        end else begin
            r_state <= n_state;
            r_akey  <= n_akey;
        end
        r_idx   <= n_idx;
        r_step  <= n_step;
        r_win   <= n_win;
        r_x     <= n_x;
        r_z     <= n_z;
        r_xseed <= n_xseed;
        r_tail  <= n_tail;
        r_a     <= n_a;
        r_b     <= n_b;
        r_chain <= n_chain;
        r_hi    <= n_hi;
    end

    assign o_stat.busy    = (r_state != S_IDLE);
    assign o_stat.autokey = r_akey;

endmodule

// ----- rtl/core/wake_key_table_byte_cipher_top.sv -----
`timescale 1ns / 1ps
// Cipher item: result registered at accept, one item per cycle unless stalled.
// Setup item: fill, add, whiten, permute and autokey passes in turn, bound by
//   the single read port of the key table RAM.
// Setup produces no result item; input ready is low while it runs.
// Reset (synchronous, active low): autokey zero, byte position on the MSB,
//   key words zero; the key table is not cleared.
// ----------------------------------------------------------------------------
// wake_key_table_byte_cipher_top: key table byte cipher top level
// Holds the key word registers, the byte position and the output register,
// and starts the setup sequencer on a build item.
// ----------------------------------------------------------------------------
module wake_key_table_byte_cipher_top
    import wkt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    // input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [7:0]           i_data_byte,
    // result item channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte
);

    t_key_words r_key;
    logic [1:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_byte;

    t_seq_stat  w_stat;
    logic       w_accept;
    logic       w_setup;
    logic       w_cipher;
    logic [7:0] w_kbyte;

    // Ready when setup is idle and the output slot is free or draining.
    assign o_in_ready = !w_stat.busy && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_setup    = w_accept && !i_command;
    assign w_cipher   = w_accept && i_command;

    wkt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_setup),
        .i_key   (r_key),
        .o_stat  (w_stat)
    );

    // Autokey byte, most significant first.
    always_comb begin
        case (r_pos)
            2'd3:    w_kbyte = w_stat.autokey[31:24];
            2'd2:    w_kbyte = w_stat.autokey[23:16];
            2'd1:    w_kbyte = w_stat.autokey[15:8];
            default: w_kbyte = w_stat.autokey[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
            r_pos       <= BYTE_POS_MSB;
            r_out_valid <= 1'b0;
        end else begin
            // writes past the last key word are dropped
            if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(KEY_WORDS))) begin
                r_key[i_cfg_index[1:0]] <= i_cfg_data;
            end
            if (w_setup) begin
                r_pos <= BYTE_POS_MSB;
            end else if (w_cipher) begin
                r_pos <= r_pos - 1'b1;
            end
            if (w_cipher) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_cipher) begin
            r_out_byte <= i_data_byte ^ w_kbyte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

    // no item is taken while the table is being built
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !o_in_ready)
        else $error("input ready during setup");

    a_setup_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_setup |=> (w_stat.busy && r_pos == BYTE_POS_MSB))
        else $error("setup item did not start the sequencer");

    a_cipher_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cipher |=> (o_out_valid && o_out_byte == $past(i_data_byte ^ w_kbyte)))
        else $error("cipher item result wrong or missing");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cipher |=> (r_pos == $past(r_pos) - 2'd1))
        else $error("byte position did not step");

    a_setup_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_setup && !o_out_valid) |=> !o_out_valid)
        else $error("setup item produced a result");

endmodule

// ----- dv/tb_wake_key_table_byte_cipher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wake_key_table_byte_cipher_top: self-checking bench for the key table cipher
// Loads key words over the config port, issues table builds and cipher bytes,
// and compares every output byte against an in-bench model of the table build,
// the autokey chain and the byte position, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_wake_key_table_byte_cipher_top;
    import wkt_pkg::*;

    // Command codes of an input item.
    localparam logic CMD_BUILD  = 1'b0;
    localparam logic CMD_CIPHER = 1'b1;

    // Config register indexes; 4..7 decode to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI  = 3'd7;

    // A build runs with no result; wait out a whole build and a little more
    // before touching the key words or closing the run.
    localparam int BUILD_SETTLE = 2200;

    localparam int N_PHASES       = 12;
    localparam int ITEMS_PER_PHASE = 86;

    // Constants of the table build, kept here apart from the RTL.
    localparam t_word MIX_WORDS [8] = '{
        32'h726a_8f3b, 32'he69a_3b5c, 32'hd3c7_1fe5, 32'hab3c_73d2,
        32'h4d3a_8eb3, 32'h0396_d6e8, 32'h3d4c_2f7a, 32'h9ee2_7cf3
    };
    localparam t_word KEEP_MASK  = 32'hFF7F_FFFF;
    localparam t_word LOW24_KEEP = 32'h00FF_FFFF;
    localparam t_word SEED_BITS  = 32'h0100_0001;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the key words, the key table, the autokey and the
    // byte position, and queues the expected output bytes.
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        t_word      key_words [4];
        t_word      key_tab [256];
        t_word      autokey;
        logic [1:0] byte_pos;
        logic [7:0] expected_bytes [$];
        int         n_fail;

        function new();
            foreach (key_words[k]) key_words[k] = '0;
            foreach (key_tab[k]) key_tab[k] = '0;
            autokey  = '0;
            byte_pos = 2'd3;
            n_fail   = 0;
        endfunction

        function void set_key(logic [CFG_IDX_W-1:0] idx, t_word value);
            if (idx < REG_UNUSED_LO)
                key_words[idx[1:0]] = value;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // M(a,b): shifted sum xor the table entry picked by its low byte
        function t_word chain_step(t_word a, t_word b);
            t_word s;
            s = a + b;
            return (s >> 8) ^ key_tab[s[7:0]];
        endfunction

        function void build_key_table();
            t_word      acc;
            t_word      whiten;
            t_word      tail;
            logic [7:0] sw;
            logic [7:0] idx;
            for (int i = 0; i < 4; i++)
                key_tab[i] = key_words[i];
            for (int i = 4; i < 256; i++) begin
                acc        = key_tab[i-1] + key_tab[i-4];
                key_tab[i] = (acc >> 3) ^ MIX_WORDS[acc[2:0]];
            end
            for (int i = 0; i < 23; i++)
                key_tab[i] = key_tab[i] + key_tab[i+89];
            // whitening
            acc    = key_tab[33];
            whiten = (key_tab[59] | SEED_BITS) & KEEP_MASK;
            acc    = (acc & KEEP_MASK) + whiten;
            for (int i = 0; i < 256; i++) begin
                acc        = (acc & KEEP_MASK) + whiten;
                key_tab[i] = (key_tab[i] & LOW24_KEEP) ^ acc;
            end
            // permutation; the slot past the end takes the old entry 0
            tail = key_tab[0];
            sw   = acc[7:0];
            for (int i = 0; i < 256; i++) begin
                idx         = 8'(i) ^ sw;
                sw          = key_tab[idx][7:0] ^ sw;
                key_tab[i]  = key_tab[sw];
                key_tab[sw] = (i < 255) ? key_tab[i+1] : tail;
            end
        endfunction

        function void derive_autokey();
            t_word r3, r4, r5;
            r3       = chain_step(key_words[0], key_words[3]);
            r4       = chain_step(key_words[1], r3);
            r5       = chain_step(key_words[2], r4);
            autokey  = chain_step(key_words[3], r5);
            byte_pos = 2'd3;
        endfunction

        // accepted input item
        function void note_item(logic cmd, logic [7:0] data);
            if (cmd == CMD_BUILD) begin
                build_key_table();
                derive_autokey();
            end else begin
                expected_bytes.push_back(data ^ autokey[8*byte_pos +: 8]);
                byte_pos = byte_pos - 2'd1;
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            n_fail++;
        endtask

        // accepted result item
        task check_byte(logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected out_byte %02h", got));
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("out_byte %02h, expected %02h", got, want));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_command;
    logic [7:0]           i_data_byte;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [7:0]           o_out_byte;

    // idle percentages of the sender and the receiver
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    cipher_scoreboard sb = new();

    wake_key_table_byte_cipher_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: a fresh ready decision on every falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Both handshakes are sampled on the rising edge; inputs only move on the
    // falling edge, so these reads never race the drivers.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_item(i_command, i_data_byte);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_byte(o_out_byte);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one item and hold it until taken. Leaves valid high on return,
    // so the next item can follow without a bubble.
    task automatic send_item(logic cmd, logic [7:0] data);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_word value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        sb.set_key(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid, drain all results, then cover a build that may still run.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (BUILD_SETTLE) @(negedge i_clk);
    endtask

    // New key words, plus one write to a dead index that must change nothing.
    task automatic load_keys(t_word k0, t_word k1, t_word k2, t_word k3);
        settle();
        write_reg(REG_KEY_WORD_0,        k0);
        write_reg(REG_KEY_WORD_0 + 3'd1, k1);
        write_reg(REG_KEY_WORD_0 + 3'd2, k2);
        write_reg(REG_KEY_WORD_0 + 3'd3, k3);
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom());
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                send_gap_pct   = 6;
                recv_stall_pct = 64;
            end
            1: begin
                send_gap_pct   = 64;
                recv_stall_pct = 6;
            end
            default: begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_word kw [4];
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_command   = CMD_CIPHER;
        i_data_byte = '0;
        set_idling(0);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Before any build the autokey is zero: bytes pass through unchanged,
        // and the position wraps past the low byte.
        send_item(CMD_CIPHER, 8'h00);
        send_item(CMD_CIPHER, 8'hFF);
        send_item(CMD_CIPHER, 8'hA5);
        send_item(CMD_CIPHER, 8'h5A);
        send_item(CMD_CIPHER, 8'h01);
        // Build from the reset key words (all zero).
        send_item(CMD_BUILD, 8'h00);
        send_item(CMD_CIPHER, 8'hFF);
        send_item(CMD_CIPHER, 8'h00);

        // All-ones keys; back-to-back builds, then a full position cycle.
        load_keys('1, '1, '1, '1);
        send_item(CMD_BUILD, 8'hFF);
        send_item(CMD_BUILD, 8'h00);
        send_item(CMD_CIPHER, 8'h00);
        send_item(CMD_CIPHER, 8'hFF);
        send_item(CMD_CIPHER, 8'h80);
        send_item(CMD_CIPHER, 8'h7F);
        send_item(CMD_CIPHER, 8'h00);
        // A build mid-word must put the position back on the top byte.
        send_item(CMD_BUILD, 8'h5A);
        send_item(CMD_CIPHER, 8'h3C);
        send_item(CMD_CIPHER, 8'hC3);

        // Random phases: each loads keys, opens with a build so the bytes run
        // on a fresh autokey, then mixes rare rebuilds into random bytes.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_idling(ph / 4);
            case (ph % 4)
                0: foreach (kw[k]) kw[k] = $urandom();
                1: foreach (kw[k]) kw[k] = '0;
                2: foreach (kw[k]) kw[k] = '1;
                default: begin
                    kw[0] = 32'hAAAA_AAAA;
                    kw[1] = 32'h5555_5555;
                    kw[2] = $urandom();
                    kw[3] = 32'h8000_0001;
                end
            endcase
            load_keys(kw[0], kw[1], kw[2], kw[3]);
            send_item(CMD_BUILD, 8'($urandom_range(0, 255)));
            repeat (ITEMS_PER_PHASE - 1) begin
                if ($urandom_range(0, 24) == 0)
                    send_item(CMD_BUILD, 8'($urandom_range(0, 255)));
                else
                    send_item(CMD_CIPHER, 8'($urandom_range(0, 255)));
            end
        end

        settle();
        if (sb.n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: the full run needs a few ms even with the heaviest stalls.
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
